/* hw/rtl/tpcr_pkg.sv */
package tpcr_pkg;

  localparam int SampleW  = 24;
  localparam int PeakW    = 23;
  localparam int ChanW    = 6;
  localparam int TimeW    = 8;
  localparam int LabelW   = 11;
  localparam int FactorW  = 16;
  localparam int ShiftW   = 8;
  localparam int SamplesW = 9;
  localparam int TolW     = 8;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;
  localparam int FracBits = 15;

  localparam logic [LabelW-1:0] MaxClusters = LabelW'(1024);

  localparam logic [CfgIdxW-1:0] RegFactor  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegShift   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegSamples = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegTol     = CfgIdxW'(3);

  localparam logic [FactorW-1:0]  FactorReset  = FactorW'(29491);
  localparam logic [ShiftW-1:0]   ShiftReset   = ShiftW'(0);
  localparam logic [SamplesW-1:0] SamplesReset = SamplesW'(64);
  localparam logic [TolW-1:0]     TolReset     = TolW'(15);

  typedef struct packed {
    logic signed [SampleW-1:0] sample_value;
    logic [ChanW-1:0]          channel_index;
    logic [TimeW-1:0]          time_index;
    logic                      last_of_template;
    logic                      first_of_set;
  } in_item_t;

  typedef struct packed {
    logic [LabelW-1:0] old_label;
    logic [LabelW-1:0] new_label;
    logic              kept;
  } out_item_t;

  typedef struct packed {
    logic [PeakW-1:0] central_peak;
    logic [PeakW-1:0] overall_peak;
    logic [TimeW-1:0] overall_peak_time;
    logic             peak_seen;
    logic             first;
  } snap_t;

  typedef struct packed {
    logic [FactorW-1:0]  ratio_factor;
    logic [ShiftW-1:0]   peak_shift;
    logic [SamplesW-1:0] samples_per_template;
    logic [TolW-1:0]     peak_tolerance;
  } cfg_t;

  function automatic logic [LabelW-1:0] advance_label(input logic [LabelW-1:0] v);
    advance_label = (v >= MaxClusters) ? LabelW'(1) : v + LabelW'(1);
  endfunction

endpackage

/* hw/rtl/tpcr_judge.sv */
module tpcr_judge (
  input  tpcr_pkg::snap_t snap,
  input  tpcr_pkg::cfg_t  cfg,
  output logic            keep
);

  localparam int ProdW = tpcr_pkg::PeakW + tpcr_pkg::FactorW;

  logic [tpcr_pkg::SamplesW:0]   t_plus;
  logic signed [11:0]            tmid;
  logic signed [11:0]            pt;
  logic signed [11:0]            d;
  logic [11:0]                   t_dist;
  logic [ProdW-1:0]              lhs;
  logic [ProdW-1:0]              rhs;
  logic                          ratio_ok;
  logic                          time_ok;

  always_comb begin
    t_plus = {1'b0, cfg.samples_per_template} + (tpcr_pkg::SamplesW + 1)'(1);
    tmid   = $signed({3'b000, t_plus[tpcr_pkg::SamplesW:1]}) - 12'sd1
             - 12'(signed'(cfg.peak_shift));
    pt     = snap.peak_seen ? $signed({4'b0000, snap.overall_peak_time}) : tmid;
    d      = pt - tmid;
    t_dist = d[11] ? 12'(-d) : 12'(d);
    time_ok = t_dist <= {4'b0000, cfg.peak_tolerance};
    lhs    = ProdW'({snap.central_peak, {tpcr_pkg::FracBits{1'b0}}});
    rhs    = ProdW'(snap.overall_peak) * ProdW'(cfg.ratio_factor);
    ratio_ok = lhs >= rhs;
    keep   = ratio_ok && time_ok;
  end

endmodule

/* hw/rtl/template_peak_check_relabel_unit.sv */
// The result of the transaction carrying last_of_template passes through the
// decision register and then the output register before out_valid rises.
// Throughput: one sample per cycle; the input stalls only while the decision
// register is full and the output register is held by a stalled receiver.
// Reset (synchronous, active low) empties the pipeline, clears the peak
// trackers and label counters and restores the configuration defaults.
module template_peak_check_relabel_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tpcr_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [tpcr_pkg::CfgDataW-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tpcr_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tpcr_pkg::out_item_t               out_data
);

  tpcr_pkg::cfg_t    cfg_r;
  tpcr_pkg::snap_t   trk_r, trk_nxt;
  logic              first_pend_r, first_pend_nxt;
  tpcr_pkg::snap_t   snap_r;
  logic              snap_valid_r, snap_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  tpcr_pkg::out_item_t out_r;
  logic [tpcr_pkg::LabelW-1:0] tcount_r, tcount_nxt;
  logic [tpcr_pkg::LabelW-1:0] nlabel_r, nlabel_nxt;
  logic [tpcr_pkg::LabelW-1:0] tc_base, nl_base;
  logic              in_acc, snap_move, keep;
  tpcr_pkg::snap_t   base;
  logic [tpcr_pkg::PeakW-1:0] raw;
  logic              positive;
  tpcr_pkg::snap_t   upd;

  tpcr_judge u_judge (
    .snap (snap_r),
    .cfg  (cfg_r),
    .keep (keep)
  );

  assign snap_move = snap_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = snap_valid_r && out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    base = trk_r;
    if (in_data.first_of_set) begin
      base = '0;
    end
    raw      = in_data.sample_value[tpcr_pkg::PeakW-1:0];
    positive = !in_data.sample_value[tpcr_pkg::SampleW-1] && (raw != '0);
    upd = base;
    if (positive) begin
      if (in_data.channel_index == '0 && raw > base.central_peak) begin
        upd.central_peak = raw;
      end
      if (raw > base.overall_peak) begin
        upd.overall_peak      = raw;
        upd.overall_peak_time = in_data.time_index;
        upd.peak_seen         = 1'b1;
      end
    end
    upd.first = first_pend_r || in_data.first_of_set;

    trk_nxt        = trk_r;
    first_pend_nxt = first_pend_r;
    snap_valid_nxt = snap_valid_r && !snap_move;
    if (in_acc) begin
      if (in_data.last_of_template) begin
        trk_nxt        = '0;
        first_pend_nxt = 1'b0;
        snap_valid_nxt = 1'b1;
      end else begin
        trk_nxt        = upd;
        first_pend_nxt = upd.first;
      end
    end
  end

  always_comb begin
    tc_base = snap_r.first ? '0 : tcount_r;
    nl_base = snap_r.first ? tpcr_pkg::LabelW'(1) : nlabel_r;
    tcount_nxt    = tcount_r;
    nlabel_nxt    = nlabel_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (snap_move) begin
      tcount_nxt    = tpcr_pkg::advance_label(tc_base);
      nlabel_nxt    = keep ? tpcr_pkg::advance_label(nl_base) : nl_base;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ratio_factor         <= tpcr_pkg::FactorReset;
      cfg_r.peak_shift           <= tpcr_pkg::ShiftReset;
      cfg_r.samples_per_template <= tpcr_pkg::SamplesReset;
      cfg_r.peak_tolerance       <= tpcr_pkg::TolReset;
    end else if (cfg_we) begin
      case (cfg_index)
        tpcr_pkg::RegFactor:  cfg_r.ratio_factor <= cfg_data;
        tpcr_pkg::RegShift:   cfg_r.peak_shift <= cfg_data[tpcr_pkg::ShiftW-1:0];
        tpcr_pkg::RegSamples: cfg_r.samples_per_template <= cfg_data[tpcr_pkg::SamplesW-1:0];
        tpcr_pkg::RegTol:     cfg_r.peak_tolerance <= cfg_data[tpcr_pkg::TolW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r        <= '0;
      first_pend_r <= 1'b0;
      snap_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      tcount_r     <= '0;
      nlabel_r     <= tpcr_pkg::LabelW'(1);
    end else begin
      trk_r        <= trk_nxt;
      first_pend_r <= first_pend_nxt;
      snap_valid_r <= snap_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      tcount_r     <= tcount_nxt;
      nlabel_r     <= nlabel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.last_of_template) begin
      snap_r <= upd;
    end
    if (snap_move) begin
      out_r.old_label <= tpcr_pkg::advance_label(tc_base);
      out_r.new_label <= keep ? nl_base : '0;
      out_r.kept      <= keep;
    end
  end

endmodule

/* hw/rtl/tpcr_checker.sv */
module tpcr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tpcr_pkg::out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled output transaction changed.");

  a_label_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.kept == (out_data.new_label != '0)) &&
                  (out_data.old_label != '0))
    else $error("Label fields disagree with the keep flag.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled without a stalled output.");

endmodule

bind template_peak_check_relabel_unit tpcr_checker u_tpcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* tb/tb_template_peak_check_relabel_unit.sv */
`timescale 1ns / 100ps

module tb_template_peak_check_relabel_unit;

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 85;
  localparam logic [tpcr_pkg::CfgIdxW-1:0] RegUnused = tpcr_pkg::CfgIdxW'(9);

  typedef struct {
    tpcr_pkg::in_item_t  item;
    bit                  typed;
    tpcr_pkg::out_item_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [tpcr_pkg::CfgIdxW-1:0] cfg_index;
  logic [tpcr_pkg::CfgDataW-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  tpcr_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  tpcr_pkg::out_item_t out_data;

  template_peak_check_relabel_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Shadow copy of the configuration and the judging state.
  logic [tpcr_pkg::FactorW-1:0] factor_q;
  logic signed [tpcr_pkg::ShiftW-1:0] shift_q;
  logic [tpcr_pkg::SamplesW-1:0] spt_q;
  logic [tpcr_pkg::TolW-1:0] tol_q;
  logic [tpcr_pkg::PeakW-1:0] central_pk;
  logic [tpcr_pkg::PeakW-1:0] overall_pk;
  logic [tpcr_pkg::TimeW-1:0] pk_time;
  bit pk_seen;
  logic [tpcr_pkg::LabelW-1:0] tmpl_count;
  logic [tpcr_pkg::LabelW-1:0] label_next;

  tpcr_pkg::out_item_t judged_q[$];
  dir_row_t dir_rows[$];

  int mismatches = 0;
  int cycles = 0;
  int n_samples = 0;
  int n_results = 0;
  int n_kept = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;

  int ph_factor[8] = '{29491, 0, 65535, 32768, 16384, 0, 65535, 1};
  int ph_shift[8] = '{0, -128, 127, -64, 64, 0, 0, -1};
  int ph_spt[8] = '{64, 1, 511, 256, 0, 0, 2, 255};
  int ph_tol[8] = '{15, 0, 255, 10, 3, 0, 0, 40};

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               judged_q.size());
      $display("template_peak_check_relabel_unit verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      0, 1: begin
        out_stall <= 1'b0;
      end
      2: begin
        out_stall <= ($urandom_range(0, 9) < 3);
      end
      default: begin
        out_stall <= ($urandom_range(0, 9) < 8);
      end
    endcase
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("Mismatch in %s: got %0d, expected %0d (cycle %0d).", what, got, want, cycles);
    mismatches++;
  endtask

  always @(posedge clk) begin : result_check
    tpcr_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (judged_q.size() == 0) begin
        report_mismatch("unexpected transaction, old_label", out_data.old_label, 0);
      end else begin
        want = judged_q.pop_front();
        n_results++;
        if (out_data.kept) n_kept++;
        if (out_data.old_label !== want.old_label)
          report_mismatch("old_label", out_data.old_label, want.old_label);
        if (out_data.new_label !== want.new_label)
          report_mismatch("new_label", out_data.new_label, want.new_label);
        if (out_data.kept !== want.kept)
          report_mismatch("kept", out_data.kept, want.kept);
      end
    end
  end

  function automatic logic [tpcr_pkg::LabelW-1:0] bump_label(
      input logic [tpcr_pkg::LabelW-1:0] v);
    return (v >= tpcr_pkg::MaxClusters) ? tpcr_pkg::LabelW'(1) : v + tpcr_pkg::LabelW'(1);
  endfunction

  function automatic int mid_index();
    return (int'(spt_q) + 1) / 2 - 1 - int'(shift_q);
  endfunction

  task automatic clear_peaks();
    central_pk = '0;
    overall_pk = '0;
    pk_time = '0;
    pk_seen = 1'b0;
  endtask

  task automatic judge_sample(input tpcr_pkg::in_item_t it, output bit fired,
                              output tpcr_pkg::out_item_t res);
    logic [tpcr_pkg::SampleW-1:0] raw;
    logic [tpcr_pkg::PeakW-1:0] mag;
    logic [63:0] lhs;
    logic [63:0] rhs;
    int mid;
    int pt;
    int t_dist;
    bit keep;
    raw = it.sample_value;
    res = '0;
    if (it.first_of_set) begin
      tmpl_count = '0;
      label_next = tpcr_pkg::LabelW'(1);
      clear_peaks();
    end
    if (!raw[tpcr_pkg::SampleW-1] && raw != '0) begin
      mag = raw[tpcr_pkg::PeakW-1:0];
      if (it.channel_index == '0 && mag > central_pk) central_pk = mag;
      if (mag > overall_pk) begin
        overall_pk = mag;
        pk_time = it.time_index;
        pk_seen = 1'b1;
      end
    end
    fired = it.last_of_template;
    if (fired) begin
      mid = mid_index();
      pt = pk_seen ? int'(pk_time) : mid;
      t_dist = pt - mid;
      if (t_dist < 0) t_dist = -t_dist;
      lhs = 64'(central_pk) << tpcr_pkg::FracBits;
      rhs = 64'(overall_pk) * 64'(factor_q);
      keep = (lhs >= rhs) && (t_dist <= int'(tol_q));
      tmpl_count = bump_label(tmpl_count);
      res.old_label = tmpl_count;
      if (keep) begin
        res.new_label = label_next;
        label_next = bump_label(label_next);
      end
      res.kept = keep;
      clear_peaks();
    end
  endtask

  task automatic drive_item(input tpcr_pkg::in_item_t it, input bit typed,
                            input tpcr_pkg::out_item_t want);
    int gap;
    bit fired;
    tpcr_pkg::out_item_t res;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    burst_left--;
    n_samples++;
    judge_sample(it, fired, res);
    if (fired) judged_q.push_back(typed ? want : res);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (judged_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tpcr_pkg::CfgIdxW-1:0] idx,
                           input logic [tpcr_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      tpcr_pkg::RegFactor: factor_q = val;
      tpcr_pkg::RegShift: shift_q = val[tpcr_pkg::ShiftW-1:0];
      tpcr_pkg::RegSamples: spt_q = val[tpcr_pkg::SamplesW-1:0];
      tpcr_pkg::RegTol: tol_q = val[tpcr_pkg::TolW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int factor, input int shift, input int spt, input int tol);
    write_reg(tpcr_pkg::RegFactor, tpcr_pkg::CfgDataW'(factor));
    write_reg(tpcr_pkg::RegShift, {8'($urandom), 8'(shift)});
    write_reg(tpcr_pkg::RegSamples, {7'($urandom), 9'(spt)});
    write_reg(tpcr_pkg::RegTol, {8'($urandom), 8'(tol)});
    if ($urandom_range(0, 1) == 0) write_reg(RegUnused, tpcr_pkg::CfgDataW'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [tpcr_pkg::SampleW-1:0] pick_value(input int mag);
    case ($urandom_range(0, 15))
      0: return '0;
      1: return 24'h7FFFFF;
      2: return 24'h800000;
      3: return {1'b1, 23'($urandom)};
      4: return 24'd1;
      default: return {1'b0, 23'(mag / 2 + $urandom_range(0, mag - mag / 2))};
    endcase
  endfunction

  function automatic dir_row_t mk_row(input logic [tpcr_pkg::SampleW-1:0] v, input int ch,
                                      input int t, input bit last, input bit first,
                                      input bit typed, input int old_l, input int new_l,
                                      input bit kept);
    dir_row_t r;
    r.item.sample_value = v;
    r.item.channel_index = tpcr_pkg::ChanW'(ch);
    r.item.time_index = tpcr_pkg::TimeW'(t);
    r.item.last_of_template = last;
    r.item.first_of_set = first;
    r.typed = typed;
    r.want.old_label = tpcr_pkg::LabelW'(old_l);
    r.want.new_label = tpcr_pkg::LabelW'(new_l);
    r.want.kept = kept;
    return r;
  endfunction

  task automatic send_template(input bit fresh_set);
    int nt;
    int nc;
    int base;
    int mag;
    bit has_center;
    bit noisy;
    tpcr_pkg::in_item_t it;
    nt = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 4);
    nc = $urandom_range(1, 4);
    has_center = ($urandom_range(0, 4) != 0);
    noisy = ($urandom_range(0, 11) == 0);
    if ($urandom_range(0, 2) != 0)
      base = mid_index() - nt / 2 + int'($urandom_range(0, 2 * int'(tol_q) + 8))
             - int'(tol_q) - 4;
    else
      base = $urandom_range(0, 255);
    mag = int'($urandom_range(1, 8388607) >> $urandom_range(0, 22));
    if (mag < 1) mag = 1;
    for (int t = 0; t < nt; t++) begin
      for (int k = 0; k < nc; k++) begin
        it.sample_value = pick_value(mag);
        it.channel_index = (k == 0 && has_center) ? '0
                           : tpcr_pkg::ChanW'($urandom_range(1, 63));
        it.time_index = tpcr_pkg::TimeW'(base + t);
        it.last_of_template = (t == nt - 1) && (k == nc - 1);
        it.first_of_set = fresh_set && t == 0 && k == 0;
        if (noisy) begin
          if ($urandom_range(0, 4) == 0) it.last_of_template = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 8) == 0) it.first_of_set = 1'b1;
          it.time_index = tpcr_pkg::TimeW'($urandom);
        end
        drive_item(it, 1'b0, '0);
      end
    end
  endtask

  initial begin
    int start;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    factor_q = tpcr_pkg::FactorReset;
    shift_q = tpcr_pkg::ShiftReset;
    spt_q = tpcr_pkg::SamplesReset;
    tol_q = tpcr_pkg::TolReset;
    clear_peaks();
    tmpl_count = '0;
    label_next = tpcr_pkg::LabelW'(1);

    dir_rows.push_back(mk_row(24'd0, 0, 0, 1, 1, 1, 1, 1, 1));
    dir_rows.push_back(mk_row(24'hFFFFFF, 0, 0, 1, 0, 1, 2, 2, 1));
    dir_rows.push_back(mk_row(24'h7FFFFF, 0, 31, 1, 0, 1, 3, 3, 1));
    dir_rows.push_back(mk_row(24'd1, 0, 31, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(24'h7FFFFF, 63, 31, 1, 0, 1, 4, 0, 0));
    dir_rows.push_back(mk_row(24'd100, 0, 255, 1, 0, 1, 5, 0, 0));
    dir_rows.push_back(mk_row(24'd500, 1, 10, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(24'd500, 0, 31, 1, 0, 1, 6, 0, 0));
    dir_rows.push_back(mk_row(24'h800000, 0, 31, 1, 0, 1, 7, 4, 1));
    dir_rows.push_back(mk_row(24'd1000, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(24'd5, 5, 31, 1, 1, 1, 1, 0, 0));
    dir_rows.push_back(mk_row(24'd7, 0, 31, 1, 0, 1, 2, 1, 1));
    dir_rows.push_back(mk_row(24'd200, 0, 30, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(24'd300, 2, 32, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(24'd290, 0, 32, 1, 0, 0, 0, 0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) drive_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    wait_drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 5)
        set_config($urandom_range(0, 65535), $urandom_range(0, 255),
                   $urandom_range(0, 511), $urandom_range(0, 255));
      else
        set_config(ph_factor[p], ph_shift[p], ph_spt[p], ph_tol[p]);
      start = n_samples;
      send_template(1'b1);
      while (n_samples - start < PhaseItems) begin
        send_template($urandom_range(0, 19) == 0);
        if ($urandom_range(0, 14) == 0) wait_drain();
      end
      wait_drain();
    end
    repeat (10) @(posedge clk);

    if (judged_q.size() != 0)
      report_mismatch("results never delivered, count", 0, judged_q.size());
    $display("Sent %0d samples under 9 register settings, with set restarts and bad framing.",
             n_samples);
    $display("Checked %0d judged templates, %0d of them kept.", n_results, n_kept);
    if (mismatches == 0) begin
      $display("template_peak_check_relabel_unit verification clean");
    end else begin
      $display("template_peak_check_relabel_unit verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/tpcr_pkg.sv
hw/rtl/tpcr_judge.sv
hw/rtl/template_peak_check_relabel_unit.sv
hw/rtl/tpcr_checker.sv
tb/tb_template_peak_check_relabel_unit.sv
